### rtl/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg
// Shared types and constants for the cloud-in-cell deposit block.
// ----------------------------------------------------------------------------
package cic_pkg;

  localparam int IDX_W  = 8;   // widest cell index, grid up to 256 per axis
  localparam int FRAC_W = 16;  // widest position fraction
  localparam int POS_W  = 16;
  localparam int CELL_W = 6;
  localparam int CFG_W  = 7;
  localparam int DENS_W = 32;

  typedef enum logic {
    OP_DEPOSIT = 1'b0,
    OP_READ    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_DEPOSIT,
    KIND_READ,
    KIND_DROP
  } kind_e;

  typedef enum logic [1:0] {
    ST_DEPOSITED = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_READ_DONE = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  // classified item as it travels from the front to the back
  typedef struct packed {
    kind_e                       kind;
    logic [2:0][IDX_W-1:0]       base;
    logic [2:0][IDX_W-1:0]       nxt;
    logic [2:0][FRAC_W-1:0]      frac;
  } entry_t;

endpackage

### rtl/cic_ram.sv
// ----------------------------------------------------------------------------
// cic_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cic_fifo.sv
// ----------------------------------------------------------------------------
// cic_fifo
// Short queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module cic_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/cic_front.sv
// ----------------------------------------------------------------------------
// cic_front
// Holds the grid size register and classifies incoming items: range check,
// base and wrapped next cell per axis, fractional weights.
// ----------------------------------------------------------------------------
module cic_front #(
  parameter int GRID      = 64,
  parameter int FRAC_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cic_pkg::CFG_W-1:0]  cfg_grid_cells_i,
  input  logic                       operation_i,
  input  logic [cic_pkg::POS_W-1:0]  pos_x_i,
  input  logic [cic_pkg::POS_W-1:0]  pos_y_i,
  input  logic [cic_pkg::POS_W-1:0]  pos_z_i,
  input  logic [cic_pkg::CELL_W-1:0] cell_x_i,
  input  logic [cic_pkg::CELL_W-1:0] cell_y_i,
  input  logic [cic_pkg::CELL_W-1:0] cell_z_i,
  output cic_pkg::entry_t            entry_o
);

  localparam int CW = $clog2(GRID);
  localparam int NW = CW + 1;
  localparam logic [8:0]  GRID9  = 9'(GRID);
  localparam logic [8:0]  MIN9   = 9'd2;
  localparam logic [16:0] ONE17  = 17'(1) << FRAC_BITS;
  localparam logic [16:0] FMASK  = ONE17 - 17'd1;

  logic [cic_pkg::CFG_W-1:0] grid_cells_q;
  logic [8:0]                g9, eff9;
  logic [NW-1:0]             eff;

  logic [2:0][cic_pkg::POS_W-1:0]  pos;
  logic [2:0][cic_pkg::CELL_W-1:0] cidx;
  logic [15:0]                     ip16, cell16;
  logic [NW-1:0]                   inc;
  logic [2:0][CW-1:0]              dep_base, dep_nxt, rd_base;
  logic                            dep_out, rd_out, is_read;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cells_q <= cic_pkg::CFG_W'(64);
    end else if (cfg_valid_i) begin
      grid_cells_q <= cfg_grid_cells_i;
    end
  end

  always_comb begin
    g9 = 9'(grid_cells_q);
    if (g9 < MIN9) begin
      eff9 = MIN9;
    end else if (g9 > GRID9) begin
      eff9 = GRID9;
    end else begin
      eff9 = g9;
    end
    eff = eff9[NW-1:0];
  end

  assign pos     = {pos_z_i, pos_y_i, pos_x_i};
  assign cidx    = {cell_z_i, cell_y_i, cell_x_i};
  assign is_read = (cic_pkg::op_e'(operation_i) == cic_pkg::OP_READ);

  always_comb begin
    dep_out = 1'b0;
    rd_out  = 1'b0;
    ip16    = '0;
    cell16  = '0;
    inc     = '0;
    for (int a = 0; a < 3; a++) begin
      ip16        = pos[a] >> FRAC_BITS;
      dep_out     = dep_out || (ip16 >= 16'(eff));
      dep_base[a] = ip16[CW-1:0];
      inc         = NW'(ip16[CW-1:0]) + NW'(1);
      dep_nxt[a]  = (inc == eff) ? '0 : inc[CW-1:0];
      cell16      = 16'(cidx[a]);
      rd_out      = rd_out || (cell16 >= 16'(eff));
      rd_base[a]  = cell16[CW-1:0];
    end
  end

  always_comb begin
    if (is_read) begin
      entry_o.kind = rd_out ? cic_pkg::KIND_DROP : cic_pkg::KIND_READ;
    end else begin
      entry_o.kind = dep_out ? cic_pkg::KIND_DROP : cic_pkg::KIND_DEPOSIT;
    end
    for (int a = 0; a < 3; a++) begin
      entry_o.base[a] = cic_pkg::IDX_W'(is_read ? rd_base[a] : dep_base[a]);
      entry_o.nxt[a]  = cic_pkg::IDX_W'(dep_nxt[a]);
      entry_o.frac[a] = pos[a] & FMASK[15:0];
    end
  end

endmodule

### rtl/cic_back.sv
// ----------------------------------------------------------------------------
// cic_back
// Executes classified items on the density grid: eight pipelined
// read-modify-write corner updates per deposit, single reads, and the
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module cic_back #(
  parameter int GRID      = 64,
  parameter int FRAC_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cic_pkg::entry_t            entry_i,
  input  logic                       entry_valid_i,
  output logic                       entry_pop_o,
  output logic                       clearing_o,
  output logic                       done_o,
  output logic [cic_pkg::DENS_W-1:0] density_o,
  output cic_pkg::status_e           status_o
);

  localparam int CW    = $clog2(GRID);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int WW    = FRAC_BITS + 1;
  localparam int XW    = 2 * WW;
  localparam int MW    = 3 * WW;
  localparam int PW    = 3 * FRAC_BITS + 1;
  localparam int SH    = 3 * FRAC_BITS;
  localparam int DSH   = (SH > 16) ? SH - 16 : 0;
  localparam int LSH   = (SH < 16) ? 16 - SH : 0;
  localparam logic [PW:0]   RND        = (PW + 1)'((64'(1) << DSH) >> 1);
  localparam logic [WW-1:0] ONE_W      = WW'(1) << FRAC_BITS;
  localparam logic [2:0]    LAST_CORNER = 3'd7;
  localparam int DW    = cic_pkg::DENS_W;

  // clearing sweep
  logic          clear_q;
  logic [AW-1:0] clr_addr_q;

  // issue stage
  logic            active_q;
  cic_pkg::entry_t cur_q;
  logic [2:0]      corner_q;
  logic            is_first, is_last;
  logic [CW-1:0]   ix, iy, iz;
  logic [AW-1:0]   iss_addr;
  logic [WW-1:0]   wx, wy, wz;
  logic [FRAC_BITS-1:0] fx, fy, fz;

  // multiply / read stage
  logic            s2_v_q, s2_first_q, s2_last_q;
  cic_pkg::kind_e  s2_kind_q;
  logic [AW-1:0]   s2_addr_q;
  logic [XW-1:0]   s2_pxy_q;
  logic [WW-1:0]   s2_wz_q;
  logic [MW-1:0]   pxyz;

  // accumulate / write stage
  logic            s3_v_q, s3_first_q, s3_last_q;
  cic_pkg::kind_e  s3_kind_q;
  logic [AW-1:0]   s3_addr_q;
  logic [PW-1:0]   s3_p_q;
  logic [DW-1:0]   s3_data_q;
  logic [DW:0]     add33, sum33;
  logic [DW-1:0]   sum_sat;
  logic            ovf, sat_all, sat_q;

  // result
  logic              done_q;
  logic [DW-1:0]     density_q;
  cic_pkg::status_e  status_q, status_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;

  assign entry_pop_o = !clear_q && !active_q && !s2_v_q && entry_valid_i;
  assign clearing_o  = clear_q;

  always_comb begin
    ix = corner_q[2] ? cur_q.nxt[0][CW-1:0] : cur_q.base[0][CW-1:0];
    iy = corner_q[1] ? cur_q.nxt[1][CW-1:0] : cur_q.base[1][CW-1:0];
    iz = corner_q[0] ? cur_q.nxt[2][CW-1:0] : cur_q.base[2][CW-1:0];
    iss_addr = {ix, iy, iz};
    fx = cur_q.frac[0][FRAC_BITS-1:0];
    fy = cur_q.frac[1][FRAC_BITS-1:0];
    fz = cur_q.frac[2][FRAC_BITS-1:0];
    wx = corner_q[2] ? WW'(fx) : ONE_W - WW'(fx);
    wy = corner_q[1] ? WW'(fy) : ONE_W - WW'(fy);
    wz = corner_q[0] ? WW'(fz) : ONE_W - WW'(fz);
    is_first = (corner_q == '0);
    is_last  = (cur_q.kind != cic_pkg::KIND_DEPOSIT) || (corner_q == LAST_CORNER);
  end

  assign pxyz = MW'(s2_pxy_q) * MW'(s2_wz_q);

  always_comb begin
    add33   = (DW + 1)'(((PW + 1)'(s3_p_q) + RND) >> DSH) << LSH;
    sum33   = {1'b0, s3_data_q} + add33;
    ovf     = sum33[DW];
    sum_sat = ovf ? '1 : sum33[DW-1:0];
    sat_all = ovf || (!s3_first_q && sat_q);
    case (s3_kind_q)
      cic_pkg::KIND_READ:    status_d = cic_pkg::ST_READ_DONE;
      cic_pkg::KIND_DEPOSIT: status_d = sat_all ? cic_pkg::ST_SATURATED
                                                : cic_pkg::ST_DEPOSITED;
      default:               status_d = cic_pkg::ST_DROPPED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
      active_q   <= 1'b0;
      corner_q   <= '0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      sat_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (clear_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clear_q <= 1'b0;
        end
      end
      if (entry_pop_o) begin
        active_q <= 1'b1;
        corner_q <= '0;
      end else if (active_q) begin
        corner_q <= corner_q + 1'b1;
        if (is_last) begin
          active_q <= 1'b0;
        end
      end
      s2_v_q <= active_q;
      s3_v_q <= s2_v_q;
      if (s3_v_q && s3_kind_q == cic_pkg::KIND_DEPOSIT) begin
        sat_q <= sat_all;
      end
      done_q <= s3_v_q && s3_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      cur_q <= entry_i;
    end
    s2_kind_q  <= cur_q.kind;
    s2_first_q <= is_first;
    s2_last_q  <= is_last;
    s2_addr_q  <= iss_addr;
    s2_pxy_q   <= XW'(wx) * XW'(wy);
    s2_wz_q    <= wz;
    s3_kind_q  <= s2_kind_q;
    s3_first_q <= s2_first_q;
    s3_last_q  <= s2_last_q;
    s3_addr_q  <= s2_addr_q;
    s3_p_q     <= pxyz[PW-1:0];
    s3_data_q  <= ram_rdata;
    if (s3_v_q && s3_last_q) begin
      status_q  <= status_d;
      density_q <= (s3_kind_q == cic_pkg::KIND_READ) ? s3_data_q : '0;
    end
  end

  assign ram_we    = clear_q || (s3_v_q && s3_kind_q == cic_pkg::KIND_DEPOSIT);
  assign ram_waddr = clear_q ? clr_addr_q : s3_addr_q;
  assign ram_wdata = clear_q ? '0 : sum_sat;

  cic_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (iss_addr),
    .rdata_o (ram_rdata)
  );

  assign done_o    = done_q;
  assign density_o = density_q;
  assign status_o  = status_q;

endmodule

### rtl/cloud_in_cell_deposit.sv
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit
// Cloud-in-cell mass deposit onto a periodic 3D density grid, with cell read.
// ----------------------------------------------------------------------------
// After reset the grid memory is swept to zero, one cell per cycle, over all
// 2**(3*ceil(log2(GRID))) cells (262144 at GRID = 64); busy stays high
// meanwhile, grid size writes are taken at any time. An item is taken when
// start is high and busy is low; up to two classified items wait in a queue
// ahead of the grid engine. The engine does one corner update per cycle on a
// one-write, one-read grid memory: eight for a deposit, one for a read or a
// dropped item. Each item gives exactly one result, in order, shown on
// density_o/status_o for the single cycle done_o is high. Results cannot be
// stalled.
module cloud_in_cell_deposit #(
  parameter int GRID      = 64,
  parameter int FRAC_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cic_pkg::CFG_W-1:0]  cfg_grid_cells_i,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [cic_pkg::POS_W-1:0]  pos_x_i,
  input  logic [cic_pkg::POS_W-1:0]  pos_y_i,
  input  logic [cic_pkg::POS_W-1:0]  pos_z_i,
  input  logic [cic_pkg::CELL_W-1:0] cell_x_i,
  input  logic [cic_pkg::CELL_W-1:0] cell_y_i,
  input  logic [cic_pkg::CELL_W-1:0] cell_z_i,
  output logic                       done_o,
  output logic [cic_pkg::DENS_W-1:0] density_o,
  output logic [1:0]                 status_o
);

  localparam int EW = $bits(cic_pkg::entry_t);

  cic_pkg::entry_t  front_entry, back_entry;
  logic [EW-1:0]    q_data;
  logic             q_full, q_valid, q_pop;
  logic             clearing;
  cic_pkg::status_e status;

  assign busy = q_full || clearing;

  cic_front #(
    .GRID      (GRID),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_grid_cells_i (cfg_grid_cells_i),
    .operation_i      (operation_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .cell_x_i         (cell_x_i),
    .cell_y_i         (cell_y_i),
    .cell_z_i         (cell_z_i),
    .entry_o          (front_entry)
  );

  cic_fifo #(
    .WIDTH (EW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !busy),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign back_entry = cic_pkg::entry_t'(q_data);

  cic_back #(
    .GRID      (GRID),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (back_entry),
    .entry_valid_i (q_valid),
    .entry_pop_o   (q_pop),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .density_o     (density_o),
    .status_o      (status)
  );

  assign status_o = status;

endmodule

### rtl/cloud_in_cell_deposit_checker.sv
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit_checker
// Port-level checks on item and result ordering for the deposit block.
// ----------------------------------------------------------------------------
module cloud_in_cell_deposit_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [cic_pkg::DENS_W-1:0] density_o,
  input logic [1:0]                 status_o
);

  logic [2:0] outstanding_q;
  logic       accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 3'(accept) - 3'(done_o);
    end
  end

  // no result without an item in flight
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> outstanding_q != 3'd0)
    else $error("result without pending item");

  // queue plus engine bound the items in flight
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 3'd4)
    else $error("too many items in flight");

  a_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back results");

  a_zero_density: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != 2'(cic_pkg::ST_READ_DONE) |-> density_o == '0)
    else $error("nonzero density on non-read result");

  // grid clear runs right out of reset
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> busy)
    else $error("not busy while clearing");

endmodule

bind cloud_in_cell_deposit cloud_in_cell_deposit_checker u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .density_o (density_o),
  .status_o  (status_o)
);
